>>> rtl/ipv4_fragment_merge_table_macros.svh
// Assertion macros for the fragment merge table RTL.
// Uses the clk and arst_n names of the module that expands them.
`ifndef IPV4_FRAGMENT_MERGE_TABLE_MACROS_SVH
`define IPV4_FRAGMENT_MERGE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define FMT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fragment merge table assertion failed");
`define FMT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fragment merge table assertion failed");
`else
`define FMT_ASSERT(lbl, prop)
`define FMT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/fmt_pkg.sv
// Shared types and constants for the fragment merge table.
// No dependencies.
`default_nettype none
package fmt_pkg;
	localparam int NUM_SESSIONS = 8;
	localparam int IDX_W = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
	localparam int SLOT_W = 3;
	localparam int IN_W = 144;
	localparam int OUT_W = 128;
	localparam logic [16:0] SIZE_LIMIT = 17'd65536;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_BAD_CKSUM = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;
	localparam logic [1:0] ST_FLUSH_DONE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE,
		S_BREAK,
		S_UPDATE,
		S_FINAL,
		S_FLUSH,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic load;
		logic match;
		logic emit_desc;
		logic desc_more;
		logic emit_status;
		logic [1:0] code;
		logic update;
		logic scan_next;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic hit;
		logic cks_ok;
		logic brk;
		logic free_hit;
		logic more;
		logic scan_valid;
		logic scan_last;
		logic out_free;
	} dp_sts_t;
endpackage
`default_nettype wire

>>> rtl/ipv4_fragment_merge_table.sv
// Top level of the IPv4 fragment merge session table.
// Depends on fmt_pkg, fmt_ctrl and fmt_dp.
//
// channel  dir  tdata fields (low bit up)                                    tuser  tlast
// s_axis   in   src_addr dst_addr frag_id protocol ip_total_len header_len     func   -
//               frag_offset more_fragments header_checksum_ok frame_len
// m_axis   out  status slot merged_len merged_offset merged_more out_src      kind   last
//               out_dst out_id out_protocol
//
// A fragment request steps through load, match over all slots, decide,
// update for a request that stores, then one state for each result put into
// the output register.
// Flush-all walks the table one slot a cycle, holding on a valid slot until the output register is free.
// A stalled output holds the sequencer; one request is worked at a time.
// Reset clears all session valid bits at once.
`default_nettype none
module ipv4_fragment_merge_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [fmt_pkg::IN_W-1:0] s_tdata, // src_addr dst_addr frag_id protocol ip_total_len header_len frag_offset more_fragments header_checksum_ok frame_len
	input wire logic s_tuser, // func
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [fmt_pkg::OUT_W-1:0] m_tdata, // status slot merged_len merged_offset merged_more out_src out_dst out_id out_protocol
	output logic m_tuser, // kind
	output logic m_tlast
);
	fmt_pkg::dp_cmd_t cmd;
	fmt_pkg::dp_sts_t sts;

	fmt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(s_tvalid && s_tready),
		.sts(sts),
		.cmd(cmd),
		.ready(s_tready)
	);

	fmt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.func(s_tuser),
		.req(s_tdata),
		.cmd(cmd),
		.sts(sts),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_kind(m_tuser),
		.out_last(m_tlast),
		.out_data(m_tdata)
	);
endmodule
`default_nettype wire

>>> rtl/fmt_ctrl.sv
// Controller state machine of the fragment merge table.
// Depends on fmt_pkg and the assertion macro header.
`default_nettype none
`include "ipv4_fragment_merge_table_macros.svh"
module fmt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire fmt_pkg::dp_sts_t sts,
	output fmt_pkg::dp_cmd_t cmd,
	output logic ready
);
	fmt_pkg::state_t state_q, state_d;
	logic [1:0] code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmt_pkg::S_IDLE;
			code_q <= fmt_pkg::ST_ACCEPTED;
		end else begin
			state_q <= state_d;
			code_q <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d = code_q;
		unique case (state_q)
			fmt_pkg::S_IDLE: begin
				if (accept) state_d = fmt_pkg::S_MATCH;
			end
			fmt_pkg::S_MATCH: begin
				state_d = sts.func ? fmt_pkg::S_FLUSH : fmt_pkg::S_DECIDE;
			end
			fmt_pkg::S_DECIDE: begin
				if (!sts.cks_ok) begin
					code_d = fmt_pkg::ST_BAD_CKSUM;
					state_d = sts.hit ? fmt_pkg::S_BREAK : fmt_pkg::S_STATUS;
				end else begin
					code_d = fmt_pkg::ST_ACCEPTED;
					state_d = sts.brk ? fmt_pkg::S_BREAK : fmt_pkg::S_UPDATE;
				end
			end
			fmt_pkg::S_BREAK: begin
				if (sts.out_free)
					state_d = (code_q == fmt_pkg::ST_BAD_CKSUM) ?
						fmt_pkg::S_STATUS : fmt_pkg::S_UPDATE;
			end
			fmt_pkg::S_UPDATE: begin
				if (!sts.hit && !sts.free_hit) begin
					code_d = fmt_pkg::ST_NO_SPACE;
					state_d = fmt_pkg::S_STATUS;
				end else begin
					state_d = sts.more ? fmt_pkg::S_STATUS : fmt_pkg::S_FINAL;
				end
			end
			fmt_pkg::S_FINAL: begin
				if (sts.out_free) state_d = fmt_pkg::S_STATUS;
			end
			fmt_pkg::S_FLUSH: begin
				if (sts.scan_last && (!sts.scan_valid || sts.out_free)) begin
					code_d = fmt_pkg::ST_FLUSH_DONE;
					state_d = fmt_pkg::S_STATUS;
				end
			end
			fmt_pkg::S_STATUS: begin
				if (sts.out_free) state_d = fmt_pkg::S_IDLE;
			end
			default: state_d = fmt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		ready = 1'b0;
		unique case (state_q)
			fmt_pkg::S_IDLE: begin
				ready = 1'b1;
				cmd.load = accept;
			end
			fmt_pkg::S_MATCH: cmd.match = !sts.func;
			fmt_pkg::S_DECIDE: cmd = '0;
			fmt_pkg::S_BREAK: begin
				cmd.emit_desc = sts.out_free;
				cmd.desc_more = 1'b1;
			end
			fmt_pkg::S_UPDATE: cmd.update = 1'b1;
			fmt_pkg::S_FINAL: begin
				cmd.emit_desc = sts.out_free;
				cmd.desc_more = 1'b0;
			end
			fmt_pkg::S_FLUSH: begin
				cmd.emit_desc = sts.scan_valid && sts.out_free;
				cmd.desc_more = 1'b1;
				cmd.scan_next = !sts.scan_valid || sts.out_free;
			end
			fmt_pkg::S_STATUS: begin
				cmd.emit_status = sts.out_free;
				cmd.code = code_q;
			end
			default: cmd = '0;
		endcase
	end

	`FMT_ASSERT(a_idle_quiet, (state_q != fmt_pkg::S_IDLE) || (!cmd.emit_desc && !cmd.emit_status))
	`FMT_ASSERT_NEXT(a_status_ends, cmd.emit_status, state_q == fmt_pkg::S_IDLE)
	`FMT_ASSERT_NEXT(a_load_match, cmd.load, state_q == fmt_pkg::S_MATCH)
	`FMT_ASSERT(a_one_emit, !(cmd.emit_desc && cmd.emit_status))
endmodule
`default_nettype wire

>>> rtl/fmt_dp.sv
// Datapath of the fragment merge table: request registers, session table,
// match logic and result register. Depends on fmt_pkg.
`default_nettype none
module fmt_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic func,
	input wire logic [fmt_pkg::IN_W-1:0] req,
	input wire fmt_pkg::dp_cmd_t cmd,
	output fmt_pkg::dp_sts_t sts,
	input wire logic out_ready,
	output logic out_valid,
	output logic out_kind,
	output logic out_last,
	output logic [fmt_pkg::OUT_W-1:0] out_data
);
	localparam int N = fmt_pkg::NUM_SESSIONS;
	localparam int IW = fmt_pkg::IDX_W;

	logic [N-1:0] valid_q;
	logic [31:0] src_q [N];
	logic [31:0] dst_q [N];
	logic [15:0] ident_q [N];
	logic [7:0] proto_q [N];
	logic [15:0] total_q [N];
	logic [15:0] start_q [N];

	logic func_q, more_q, cks_q;
	logic [31:0] rsrc_q, rdst_q;
	logic [15:0] rid_q, tlen_q, flen_q, off_q;
	logic [7:0] rproto_q;
	logic [5:0] hlen_q;

	logic hit_q;
	logic [N-1:0] free_q;
	logic [IW-1:0] cur_q;

	logic [N-1:0] hit_vec;
	logic [IW-1:0] hit_idx, free_idx;
	logic any_hit, any_free;
	logic [16:0] end_sess, end_frag, size_sum, add_sum;
	logic [15:0] pay_len, sat_total;

	always_comb begin
		hit_idx = '0;
		any_hit = 1'b0;
		free_idx = '0;
		any_free = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			hit_vec[i] = valid_q[i] && src_q[i] == rsrc_q && dst_q[i] == rdst_q &&
				ident_q[i] == rid_q && proto_q[i] == rproto_q;
			if (hit_vec[i]) begin
				hit_idx = IW'(i);
				any_hit = 1'b1;
			end
			if (free_q[i]) begin
				free_idx = IW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign end_sess = {1'b0, start_q[cur_q]} + {1'b0, total_q[cur_q]};
	assign end_frag = {1'b0, off_q} + 17'(hlen_q);
	assign size_sum = {1'b0, total_q[cur_q]} + {1'b0, flen_q};
	assign pay_len = (tlen_q > 16'(hlen_q)) ? tlen_q - 16'(hlen_q) : 16'd0;
	assign add_sum = {1'b0, total_q[cur_q]} + {1'b0, pay_len};
	assign sat_total = add_sum[16] ? 16'hFFFF : add_sum[15:0];

	always_comb begin
		sts.func = func_q;
		sts.hit = hit_q;
		sts.cks_ok = cks_q;
		sts.brk = hit_q && (end_sess != end_frag || size_sum > fmt_pkg::SIZE_LIMIT);
		sts.free_hit = any_free;
		sts.more = more_q;
		sts.scan_valid = valid_q[cur_q];
		sts.scan_last = cur_q == IW'(N - 1);
		sts.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			rsrc_q <= req[31:0];
			rdst_q <= req[63:32];
			rid_q <= req[79:64];
			rproto_q <= req[87:80];
			tlen_q <= req[103:88];
			hlen_q <= req[109:104];
			off_q <= {req[122:110], 3'b000};
			more_q <= req[123];
			cks_q <= req[124];
			flen_q <= req[140:125];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= '0;
		end else if (cmd.match) begin
			hit_q <= any_hit;
			free_q <= ~valid_q;
			cur_q <= hit_idx;
		end else if (cmd.update && !hit_q && any_free) begin
			cur_q <= free_idx;
		end else if (cmd.scan_next) begin
			cur_q <= cur_q + IW'(1);
		end
		if (cmd.emit_desc && !cmd.scan_next) begin
			hit_q <= 1'b0;
			free_q[cur_q] <= 1'b1;
		end
		if (cmd.update) begin
			if (hit_q) begin
				total_q[cur_q] <= sat_total;
			end else if (any_free) begin
				src_q[free_idx] <= rsrc_q;
				dst_q[free_idx] <= rdst_q;
				ident_q[free_idx] <= rid_q;
				proto_q[free_idx] <= rproto_q;
				total_q[free_idx] <= tlen_q;
				start_q[free_idx] <= off_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.emit_desc) valid_q[cur_q] <= 1'b0;
			if (cmd.update && !hit_q && any_free) valid_q[free_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_desc || cmd.emit_status) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_desc) begin
			out_kind <= 1'b1;
			out_last <= 1'b0;
			out_data <= {5'd0, proto_q[cur_q], ident_q[cur_q], dst_q[cur_q], src_q[cur_q],
				cmd.desc_more, start_q[cur_q][15:3], total_q[cur_q],
				fmt_pkg::SLOT_W'(cur_q), fmt_pkg::ST_ACCEPTED};
		end else if (cmd.emit_status) begin
			out_kind <= 1'b0;
			out_last <= 1'b1;
			out_data <= {126'd0, cmd.code};
		end
	end
endmodule
`default_nettype wire
